>>> hdl/conv2d_3x3_zero_pad_stream_top_macros.svh
// Assertion helpers used by the block's job queue.
// Each expects clk and arst_n in scope.
`ifndef CONV2D_3X3_ZERO_PAD_STREAM_TOP_MACROS_SVH
`define CONV2D_3X3_ZERO_PAD_STREAM_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define C2DZP_AST_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);
`define C2DZP_AST_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);
`else
`define C2DZP_AST_IMP(lbl, ante, cons, msg)
`define C2DZP_AST_NXT(lbl, ante, cons, msg)
`endif
`endif

>>> hdl/c2dzp_pkg.sv
`default_nettype none
package c2dzp_pkg;
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int ADDR_W     = $clog2(MAX_WIDTH);
	localparam int EW_W       = $clog2(MAX_WIDTH + 1);
	localparam int ROW_W      = $clog2(MAX_HEIGHT);
	localparam int EH_W       = $clog2(MAX_HEIGHT + 1);
	localparam int DIM_W      = 11;
	localparam int PIX_W      = 8;
	localparam int TAP_W      = 24;
	localparam int TAPS       = 9;
	localparam int RES_W      = 20;
	localparam int CNT_W      = 21;
	localparam int DIV_W      = 11;
	localparam int CFG_W      = 24;
	localparam int CFG_IDX_W  = 3;
	localparam int STEP_W     = $clog2(RES_W);
	localparam int TIDX_W     = $clog2(TAPS);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KROW_TOP    = 3'd0,
		REG_KROW_MIDDLE = 3'd1,
		REG_KROW_BOTTOM = 3'd2,
		REG_NORMALIZE   = 3'd3,
		REG_COLOR       = 3'd4,
		REG_WIDTH       = 3'd5,
		REG_HEIGHT      = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic [TAPS-1:0][TAP_W-1:0] taps;
		logic                       frame_last;
	} job_t;

	typedef struct packed {
		logic [2:0][CFG_W-1:0] krows;
		logic                  norm;
		logic                  color;
	} back_cfg_t;

	function automatic logic signed [7:0] coef_at(input logic [2:0][CFG_W-1:0] krows,
			input logic [TIDX_W-1:0] idx);
		logic signed [7:0] c;
		case (idx)
			4'd0: c = krows[0][7:0];
			4'd1: c = krows[0][15:8];
			4'd2: c = krows[0][23:16];
			4'd3: c = krows[1][7:0];
			4'd4: c = krows[1][15:8];
			4'd5: c = krows[1][23:16];
			4'd6: c = krows[2][7:0];
			4'd7: c = krows[2][15:8];
			4'd8: c = krows[2][23:16];
			default: c = '0;
		endcase
		return c;
	endfunction

	function automatic logic [DIV_W-1:0] div_total(input logic [2:0][CFG_W-1:0] krows);
		logic [DIV_W-1:0] t;
		logic signed [7:0] k;
		t = '0;
		for (int i = 0; i < TAPS; i++) begin
			k = coef_at(krows, TIDX_W'(i));
			if (k > 0)
				t = t + DIV_W'(k);
		end
		return (t == '0) ? DIV_W'(1) : t;
	endfunction
endpackage
`default_nettype wire

>>> hdl/c2dzp_front.sv
`default_nettype none
module c2dzp_front import c2dzp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic             func,
	input  logic [PIX_W-1:0] pixel_ch0,
	input  logic [PIX_W-1:0] pixel_ch1,
	input  logic [PIX_W-1:0] pixel_ch2,
	input  logic [DIM_W-1:0] image_width,
	input  logic [DIM_W-1:0] image_height,
	output job_t             job,
	output logic             job_push,
	input  logic             job_full
);
	typedef enum logic [1:0] {F_IDLE = 2'b01, F_WRITE = 2'b10} fstate_t;

	fstate_t            state_q;
	logic [TAP_W-1:0]   pix_q;
	logic [ADDR_W-1:0]  col_q;
	logic               emit_q, last_q;
	logic [3:0]         mask_q; // top row, bottom row, left col, right col
	logic [CNT_W-1:0]   cnt_q;
	logic [ADDR_W-1:0]  out_col_q;
	logic [ROW_W-1:0]   out_row_q;
	logic [TAPS-1:0][TAP_W-1:0] win_q;
	logic [TAP_W-1:0]   up_rd_q, lo_rd_q;
	logic [TAP_W-1:0]   up_mem [MAX_WIDTH];
	logic [TAP_W-1:0]   lo_mem [MAX_WIDTH];

	logic [EW_W-1:0]    w, next_col;
	logic [EH_W-1:0]    h, next_row;
	logic               accept, advance, emit, last_col, last_row;
	logic [ADDR_W-1:0]  col;
	logic [CNT_W-1:0]   cnt_inc;
	logic [TAPS-1:0][TAP_W-1:0] nwin;

	always_comb begin
		if (image_width == '0)
			w = EW_W'(1);
		else if (image_width > DIM_W'(MAX_WIDTH))
			w = EW_W'(MAX_WIDTH);
		else
			w = EW_W'(image_width);
		if (image_height == '0)
			h = EH_W'(1);
		else if (image_height > DIM_W'(MAX_HEIGHT))
			h = EH_W'(MAX_HEIGHT);
		else
			h = EH_W'(image_height);
	end

	assign accept   = push && (state_q == F_IDLE);
	assign full     = (state_q != F_IDLE);
	assign next_col = EW_W'(out_col_q) + EW_W'(1);
	assign next_row = EH_W'(out_row_q) + EH_W'(1);
	assign emit     = (CNT_W+1)'(cnt_q) >= ((CNT_W+1)'(w) + (CNT_W+1)'(1));
	assign last_col = next_col >= w;
	assign last_row = next_row >= h;
	assign cnt_inc  = (cnt_q == {CNT_W{1'b1}}) ? cnt_q : cnt_q + CNT_W'(1);

	always_comb begin
		if (emit)
			col = (next_col < w) ? next_col[ADDR_W-1:0] : '0;
		else
			col = (cnt_q < CNT_W'(w)) ? cnt_q[ADDR_W-1:0] : '0;
	end

	assign advance = (state_q == F_WRITE) && !(emit_q && job_full);

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			nwin[r*3]   = win_q[r*3+1];
			nwin[r*3+1] = win_q[r*3+2];
		end
		nwin[2] = up_rd_q;
		nwin[5] = lo_rd_q;
		nwin[8] = pix_q;
		for (int i = 0; i < TAPS; i++) begin
			job.taps[i] = nwin[i];
			if ((i / 3 == 0 && mask_q[3]) || (i / 3 == 2 && mask_q[2]) ||
					(i % 3 == 0 && mask_q[1]) || (i % 3 == 2 && mask_q[0]))
				job.taps[i] = '0;
		end
		job.frame_last = last_q;
	end
	assign job_push = advance && emit_q;

	// line stores: read on accept, write back when the window advances
	always_ff @(posedge clk) begin
		if (accept) begin
			up_rd_q <= up_mem[col];
			lo_rd_q <= lo_mem[col];
		end
		if (advance) begin
			up_mem[col_q] <= lo_rd_q;
			lo_mem[col_q] <= pix_q;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_q  <= func ? '0 : {pixel_ch2, pixel_ch1, pixel_ch0};
			col_q  <= col;
			emit_q <= emit;
			last_q <= last_col && last_row;
			mask_q <= {out_row_q == '0, last_row, out_col_q == '0, last_col};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= F_IDLE;
			cnt_q     <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			win_q     <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (accept) begin
						state_q <= F_WRITE;
						if (emit && last_col && last_row)
							cnt_q <= '0;
						else
							cnt_q <= cnt_inc;
						if (emit) begin
							if (last_col && last_row) begin
								out_col_q <= '0;
								out_row_q <= '0;
							end else if (last_col) begin
								out_col_q <= '0;
								out_row_q <= next_row[ROW_W-1:0];
							end else begin
								out_col_q <= next_col[ADDR_W-1:0];
							end
						end
					end
				end
				F_WRITE: begin
					if (advance) begin
						win_q   <= nwin;
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

>>> hdl/c2dzp_jobq.sv
`default_nettype none
`include "conv2d_3x3_zero_pad_stream_top_macros.svh"
module c2dzp_jobq import c2dzp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  job_t wr_job,
	input  logic wr_en,
	output logic full,
	output job_t rd_job,
	input  logic rd_en,
	output logic empty
);
	job_t       mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;

	assign full   = (count_q == 2'd2);
	assign empty  = (count_q == 2'd0);
	assign rd_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en && !full)
			mem_q[wr_ptr_q] <= wr_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (wr_en && !full)
				wr_ptr_q <= !wr_ptr_q;
			if (rd_en && !empty)
				rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + 2'((wr_en && !full) ? 1 : 0) - 2'((rd_en && !empty) ? 1 : 0);
		end
	end

	`C2DZP_AST_IMP(a_no_push_full, full, !wr_en, "job pushed into a full queue")
	`C2DZP_AST_IMP(a_no_pop_empty, empty, !rd_en, "job taken from an empty queue")
	`C2DZP_AST_NXT(a_ptr_count, (count_q == 2'd0 || count_q == 2'd2),
		(wr_ptr_q == rd_ptr_q) || (count_q == 2'd1), "queue pointers disagree with count")
endmodule
`default_nettype wire

>>> hdl/c2dzp_back.sv
`default_nettype none
module c2dzp_back import c2dzp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  back_cfg_t        cfg,
	input  job_t             job,
	input  logic             job_empty,
	output logic             job_pop,
	output logic             empty,
	input  logic             pop,
	output logic [RES_W-1:0] result_ch0,
	output logic [RES_W-1:0] result_ch1,
	output logic [RES_W-1:0] result_ch2,
	output logic             frame_last
);
	typedef enum logic [4:0] {
		B_IDLE = 5'b00001, B_MAC = 5'b00010, B_PREP = 5'b00100,
		B_DIV = 5'b01000, B_OUT = 5'b10000
	} bstate_t;

	bstate_t                      state_q;
	logic [TAPS-1:0][TAP_W-1:0]   taps_q;
	logic                         last_q, out_valid_q;
	logic [TIDX_W-1:0]            tidx_q;
	logic [STEP_W-1:0]            step_q;
	logic [DIV_W-1:0]             divisor_q;
	logic signed [RES_W-1:0]      acc_q [3];
	logic [RES_W-1:0]             quo_q [3];
	logic [DIV_W-1:0]             rem_q [3];
	logic                         neg_q [3];
	logic [RES_W-1:0]             res [3];
	logic signed [7:0]            coef;
	logic signed [16:0]           prod [3];
	logic [DIV_W:0]               trial [3];
	logic                         ge [3];
	logic                         out_load;

	assign coef     = coef_at(cfg.krows, tidx_q);
	assign job_pop  = (state_q == B_IDLE) && !job_empty;
	assign out_load = (state_q == B_OUT) && (!out_valid_q || pop);
	assign empty    = !out_valid_q;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			prod[c]  = coef * $signed({1'b0, taps_q[tidx_q][c*PIX_W +: PIX_W]});
			trial[c] = {rem_q[c], quo_q[c][RES_W-1]};
			ge[c]    = trial[c] >= {1'b0, divisor_q};
			if (cfg.norm)
				res[c] = neg_q[c] ? -quo_q[c] : quo_q[c];
			else
				res[c] = acc_q[c];
			if (c != 0 && !cfg.color)
				res[c] = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (job_pop) begin
			taps_q <= job.taps;
			last_q <= job.frame_last;
		end
		for (int c = 0; c < 3; c++) begin
			if (job_pop)
				acc_q[c] <= '0;
			else if (state_q == B_MAC)
				acc_q[c] <= acc_q[c] + RES_W'(prod[c]);
			if (state_q == B_PREP) begin
				neg_q[c] <= acc_q[c] < 0;
				quo_q[c] <= (acc_q[c] < 0) ? RES_W'(-acc_q[c]) : RES_W'(acc_q[c]);
				rem_q[c] <= '0;
			end else if (state_q == B_DIV) begin
				rem_q[c] <= ge[c] ? DIV_W'(trial[c] - {1'b0, divisor_q}) : trial[c][DIV_W-1:0];
				quo_q[c] <= {quo_q[c][RES_W-2:0], ge[c]};
			end
		end
		if (out_load) begin
			result_ch0 <= res[0];
			result_ch1 <= res[1];
			result_ch2 <= res[2];
			frame_last <= last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			tidx_q      <= '0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
			divisor_q   <= DIV_W'(1);
		end else begin
			divisor_q <= div_total(cfg.krows);
			if (out_load)
				out_valid_q <= 1'b1;
			else if (pop)
				out_valid_q <= 1'b0;
			unique case (state_q)
				B_IDLE: begin
					if (job_pop) begin
						tidx_q  <= '0;
						state_q <= B_MAC;
					end
				end
				B_MAC: begin
					tidx_q <= tidx_q + TIDX_W'(1);
					if (tidx_q == TIDX_W'(TAPS - 1))
						state_q <= B_PREP;
				end
				B_PREP: begin
					step_q  <= '0;
					state_q <= cfg.norm ? B_DIV : B_OUT;
				end
				B_DIV: begin
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(RES_W - 1))
						state_q <= B_OUT;
				end
				B_OUT: begin
					if (out_load)
						state_q <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

>>> hdl/conv2d_3x3_zero_pad_stream_top.sv
// 3x3 convolution over a raster pixel stream, zero outside the image.
// Input side is a queue: drive func and pixel_ch0..2 with push; the item
// is taken on a clock edge with push high and full low. func high marks a
// drain item (pixel read as zero); send image_width + 1 of them after the
// frame to flush the last results.
// Result side is a queue too: while empty is low the oldest result sits on
// result_ch0..2 and frame_last; it is taken on an edge with pop high.
// The front takes a new item only once the last is written back (one
// line-store read, one write). Each emitting item then runs 9 multiply-add
// steps over the window, sign prep and output load in the back end; with
// normalize on, a 20-step restoring divider runs per channel between prep
// and load. A two-entry job queue sits between front and back; the output
// register lets the back end start the next job while a result waits for
// pop. Reset clears counters, the window and the queues; line stores need
// no clearing pass. Stalling pop backs up the queue and then raises full.
// Configuration is written through cfg_wr_en/cfg_index/cfg_data; the user
// must do so only while idle, as the block does not enforce it.
`default_nettype none
module conv2d_3x3_zero_pad_stream_top import c2dzp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 push,
	output logic                 full,
	input  logic                 func,
	input  logic [PIX_W-1:0]     pixel_ch0,
	input  logic [PIX_W-1:0]     pixel_ch1,
	input  logic [PIX_W-1:0]     pixel_ch2,
	output logic                 empty,
	input  logic                 pop,
	output logic [RES_W-1:0]     result_ch0,
	output logic [RES_W-1:0]     result_ch1,
	output logic [RES_W-1:0]     result_ch2,
	output logic                 frame_last
);
	back_cfg_t        cfg_q;
	logic [DIM_W-1:0] width_q, height_q;
	job_t             fr_job, q_job;
	logic             fr_push, q_full, q_empty, q_pop;

	// configuration registers; undefined indices are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q    <= '0;
			width_q  <= DIM_W'(1024);
			height_q <= DIM_W'(1024);
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_KROW_TOP:    cfg_q.krows[0] <= cfg_data;
				REG_KROW_MIDDLE: cfg_q.krows[1] <= cfg_data;
				REG_KROW_BOTTOM: cfg_q.krows[2] <= cfg_data;
				REG_NORMALIZE:   cfg_q.norm     <= cfg_data[0];
				REG_COLOR:       cfg_q.color    <= cfg_data[0];
				REG_WIDTH:       width_q        <= cfg_data[DIM_W-1:0];
				REG_HEIGHT:      height_q       <= cfg_data[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	// front: classify the item, advance the line stores and the window
	c2dzp_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .func(func),
		.pixel_ch0(pixel_ch0), .pixel_ch1(pixel_ch1), .pixel_ch2(pixel_ch2),
		.image_width(width_q), .image_height(height_q),
		.job(fr_job), .job_push(fr_push), .job_full(q_full)
	);

	// hold masked windows between the two halves
	c2dzp_jobq u_jobq (
		.clk(clk), .arst_n(arst_n), .wr_job(fr_job), .wr_en(fr_push), .full(q_full),
		.rd_job(q_job), .rd_en(q_pop), .empty(q_empty)
	);

	// back: multiply-accumulate, optional divide, result register
	c2dzp_back u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .job(q_job), .job_empty(q_empty),
		.job_pop(q_pop), .empty(empty), .pop(pop),
		.result_ch0(result_ch0), .result_ch1(result_ch1), .result_ch2(result_ch2),
		.frame_last(frame_last)
	);
endmodule
`default_nettype wire
